// ===== rtl/core/dfr_pkg.sv =====
// Shared types and constants for the two-section frame deframer.
// Used by every module in rtl/core; depends on nothing else.
package dfr_pkg;

    // Field widths fixed by the byte stream and the result format.
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 14;
    localparam int RLEN_W   = 9;
    localparam int CLEN_W   = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // Default cap on the length of one section.
    localparam int DEFAULT_MAX_SECTION_BYTES = 16384;

    // Framing bytes.
    localparam logic [BYTE_W-1:0] SYNC_FIRST    = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND   = 8'h55;
    localparam logic [BYTE_W-1:0] TYPE_RANGING  = 8'h01;
    localparam logic [BYTE_W-1:0] TYPE_WITH_CIR = 8'h02;
    localparam logic [BYTE_W-1:0] XOR_START     = 8'h00;

    // Register reset values.
    localparam logic [RLEN_W-1:0] RANGING_LENGTH_RESET = 9'd216;
    localparam logic [CLEN_W-1:0] CIR_LENGTH_RESET     = 14'd8128;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_RANGING_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CIR_LENGTH     = 2'd1;

    // Result codes.
    localparam logic KIND_PAYLOAD    = 1'b0;
    localparam logic KIND_VERDICT    = 1'b1;
    localparam logic SECTION_RANGING = 1'b0;
    localparam logic SECTION_CIR     = 1'b1;
    localparam logic FRAME_RANGING   = 1'b0;
    localparam logic FRAME_WITH_CIR  = 1'b1;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_TYPE    = 3'd2,
        PH_RANGING = 3'd3,
        PH_RCHECK  = 3'd4,
        PH_CIR     = 3'd5,
        PH_CCHECK  = 3'd6
    } phase_t;

    // One result beat.
    typedef struct packed {
        logic                kind;
        logic                section;
        logic [OFFSET_W-1:0] offset;
        logic [BYTE_W-1:0]   payload_byte;
        logic                check_ok;
        logic                frame_end;
    } result_t;

endpackage

// ===== rtl/core/two_section_frame_deframer.sv =====
// Top level of the two-section frame deframer.
// Depends on dfr_pkg, dfr_cfg_regs, dfr_parser and dfr_out_stage.
//
// Usage:
//   Input channel: one received byte per beat on rx_byte, with in_valid and
//   in_stall. Output channel: one result beat with kind, section, offset,
//   payload_byte, check_ok and frame_end, with out_valid and out_stall.
//   Sync bytes, the type byte and hunting bytes give no result; each payload
//   byte gives a pass-through beat and each checksum byte a verdict beat.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//   sets ranging_length, index 1 sets cir_length, others are ignored.
//   cfg_ready is always high; write only while the block is idle.
//   Path: an accepted byte sits in the input register; when it moves on,
//   its result is loaded into the output register and offered from there.
//   Throughput: one byte per cycle unless a result finds the output held;
//   the parser state update and the XOR are combinational between the registers.
//   Receiver stall: the output register holds its beat; a byte that makes a
//   result waits in the input register, which then raises in_stall. Bytes
//   that make no result keep flowing.
//   Reset: the parser returns to the sync hunt, both registers of the
//   stream empty, and the lengths return to 216 and 8128.
module two_section_frame_deframer #(
    parameter int MAX_SECTION_BYTES = dfr_pkg::DEFAULT_MAX_SECTION_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [dfr_pkg::BYTE_W-1:0]     rx_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           kind,
    output logic                           section,
    output logic [dfr_pkg::OFFSET_W-1:0]   offset,
    output logic [dfr_pkg::BYTE_W-1:0]     payload_byte,
    output logic                           check_ok,
    output logic                           frame_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dfr_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              advance;
    logic              has_result;
    logic              out_free;
    result_t           parse_result;
    result_t           out_result;
    logic [RLEN_W-1:0] ranging_length;
    logic [CLEN_W-1:0] cir_length;

    assign cfg_ready = 1'b1;

    dfr_cfg_regs u_cfg_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .ranging_length (ranging_length),
        .cir_length     (cir_length)
    );

    // The byte in hand moves on unless its result finds the output held.
    assign advance  = in_valid_reg && (!has_result || out_free);
    assign in_stall = in_valid_reg && !advance;

    // Input register.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && !in_stall)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= rx_byte;
    end

    dfr_parser #(
        .MAX_SECTION_BYTES (MAX_SECTION_BYTES)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .rx_byte        (in_byte_reg),
        .ranging_length (ranging_length),
        .cir_length     (cir_length),
        .has_result     (has_result),
        .result         (parse_result)
    );

    dfr_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && has_result),
        .load_result (parse_result),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_free    (out_free),
        .out_result  (out_result)
    );

    assign kind         = out_result.kind;
    assign section      = out_result.section;
    assign offset       = out_result.offset;
    assign payload_byte = out_result.payload_byte;
    assign check_ok     = out_result.check_ok;
    assign frame_end    = out_result.frame_end;

    // A result is never loaded over a beat that the receiver is holding.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && has_result) |-> !(out_valid && out_stall))
        else $error("result loaded over a stalled output beat");

    // A byte that cannot move on stays in the input register unchanged.
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held input byte was lost or changed");

    // Once the output beat leaves, the register is full again only by a new load.
    a_out_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (!out_valid || $past(advance && has_result)))
        else $error("output beat repeated without a new result");

endmodule

// ===== rtl/core/dfr_cfg_regs.sv =====
// Configuration registers holding the two section lengths.
// Depends on dfr_pkg for widths, indexes and reset values.
module dfr_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfr_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [dfr_pkg::RLEN_W-1:0]     ranging_length,
    output logic [dfr_pkg::CLEN_W-1:0]     cir_length
);
    import dfr_pkg::*;

    logic [RLEN_W-1:0] ranging_length_reg;
    logic [CLEN_W-1:0] cir_length_reg;
    logic [RLEN_W-1:0] ranging_length_next;
    logic [CLEN_W-1:0] cir_length_next;

    // Decode the write; indexes beyond the list are ignored.
    always_comb
    begin
        ranging_length_next = ranging_length_reg;
        cir_length_next     = cir_length_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RANGING_LENGTH: ranging_length_next = cfg_data[RLEN_W-1:0];
                CFG_CIR_LENGTH:     cir_length_next     = cfg_data[CLEN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ranging_length_reg <= RANGING_LENGTH_RESET;
            cir_length_reg     <= CIR_LENGTH_RESET;
        end
        else
        begin
            ranging_length_reg <= ranging_length_next;
            cir_length_reg     <= cir_length_next;
        end
    end

    assign ranging_length = ranging_length_reg;
    assign cir_length     = cir_length_reg;

endmodule

// ===== rtl/core/dfr_parser.sv =====
// Frame parser: sync hunt, section counting, running XOR and verdicts.
// Depends on dfr_pkg for the phase type, the result struct and constants.
module dfr_parser #(
    parameter int MAX_SECTION_BYTES = dfr_pkg::DEFAULT_MAX_SECTION_BYTES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [dfr_pkg::BYTE_W-1:0] rx_byte,
    input  logic [dfr_pkg::RLEN_W-1:0] ranging_length,
    input  logic [dfr_pkg::CLEN_W-1:0] cir_length,
    output logic                       has_result,
    output dfr_pkg::result_t           result
);
    import dfr_pkg::*;

    localparam int LEN_W = $clog2(MAX_SECTION_BYTES + 1);
    localparam int CMP_W = (LEN_W > OFFSET_W + 1) ? LEN_W : OFFSET_W + 1;
    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_SECTION_BYTES);

    phase_t              phase_reg, phase_next;
    logic [OFFSET_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0]   xor_reg, xor_next;
    logic                frame_kind_reg, frame_kind_next;

    logic [CLEN_W-1:0]   sel_len;
    logic [CMP_W-1:0]    eff_len;
    logic [OFFSET_W:0]   count_inc;

    // Effective length of the current section: zero acts as one, capped above.
    always_comb
    begin
        sel_len = (phase_reg == PH_CIR) ? cir_length : CLEN_W'(ranging_length);
        if (sel_len == '0)
            eff_len = CMP_W'(1);
        else if (CMP_W'(sel_len) > MAX_LEN)
            eff_len = MAX_LEN;
        else
            eff_len = CMP_W'(sel_len);
    end

    assign count_inc = {1'b0, count_reg} + (OFFSET_W + 1)'(1);

    // Next state and the result of the byte in hand.
    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        xor_next        = xor_reg;
        frame_kind_next = frame_kind_reg;
        has_result      = 1'b0;
        result          = '0;
        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == SYNC_FIRST)
                    phase_next = PH_SYNC2;
                else
                begin
                    count_next = '0;
                    xor_next   = XOR_START;
                end
            end
            PH_SYNC2:
            begin
                if (rx_byte == SYNC_SECOND)
                    phase_next = PH_TYPE;
                else
                begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                    xor_next   = XOR_START;
                end
            end
            PH_TYPE:
            begin
                if (rx_byte == TYPE_RANGING || rx_byte == TYPE_WITH_CIR)
                begin
                    frame_kind_next = (rx_byte == TYPE_WITH_CIR) ? FRAME_WITH_CIR
                                                                 : FRAME_RANGING;
                    phase_next = PH_RANGING;
                end
                else
                    phase_next = PH_HUNT;
                count_next = '0;
                xor_next   = XOR_START;
            end
            PH_RANGING, PH_CIR:
            begin
                has_result          = 1'b1;
                result.kind         = KIND_PAYLOAD;
                result.section      = (phase_reg == PH_CIR) ? SECTION_CIR
                                                            : SECTION_RANGING;
                result.offset       = count_reg;
                result.payload_byte = rx_byte;
                xor_next            = xor_reg ^ rx_byte;
                count_next          = count_inc[OFFSET_W-1:0];
                if (CMP_W'(count_inc) >= eff_len)
                    phase_next = (phase_reg == PH_CIR) ? PH_CCHECK : PH_RCHECK;
            end
            PH_RCHECK:
            begin
                has_result      = 1'b1;
                result.kind     = KIND_VERDICT;
                result.section  = SECTION_RANGING;
                result.check_ok = (rx_byte == xor_reg);
                count_next      = '0;
                xor_next        = XOR_START;
                if (frame_kind_reg == FRAME_WITH_CIR)
                    phase_next = PH_CIR;
                else
                begin
                    result.frame_end = 1'b1;
                    phase_next       = PH_HUNT;
                end
            end
            PH_CCHECK:
            begin
                has_result       = 1'b1;
                result.kind      = KIND_VERDICT;
                result.section   = SECTION_CIR;
                result.check_ok  = (rx_byte == xor_reg);
                result.frame_end = 1'b1;
                phase_next       = PH_HUNT;
                count_next       = '0;
                xor_next         = XOR_START;
            end
            default:
            begin
                phase_next = PH_HUNT;
                count_next = '0;
                xor_next   = XOR_START;
            end
        endcase
    end

    // Parser state advances only when the byte in hand moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            count_reg      <= '0;
            xor_reg        <= XOR_START;
            frame_kind_reg <= FRAME_RANGING;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            xor_reg        <= xor_next;
            frame_kind_reg <= frame_kind_next;
        end
    end

endmodule

// ===== rtl/core/dfr_out_stage.sv =====
// Output register holding one result beat until the receiver takes it.
// Depends on dfr_pkg for the result struct.
module dfr_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  dfr_pkg::result_t load_result,
    input  logic             out_stall,
    output logic             out_valid,
    output logic             out_free,
    output dfr_pkg::result_t out_result
);
    import dfr_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t result_reg;

    // The register is free when empty or when its beat leaves this cycle.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= load_result;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule
